/* rtl/core/ppmenc_pkg.sv */
package ppmenc_pkg;

  // Fixed field widths
  localparam int LevelW    = 32;
  localparam int ScaledW   = 40;
  localparam int DimW      = 12;
  localparam int LimitW    = 8;
  localparam int ColW      = 14;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;
  localparam int BcdW      = 16;
  localparam int ValBcdW   = 12;

  // Defaults for top-level parameters
  localparam int DimBitsDefault    = 12;
  localparam int QueueDepthDefault = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimit  = 2'd2;

  // Register reset values
  localparam logic [DimW-1:0]   WidthReset  = 12'd1;
  localparam logic [DimW-1:0]   HeightReset = 12'd1;
  localparam logic [LimitW-1:0] LimitReset  = 8'd70;
  localparam logic [BcdW-1:0]   BcdOne      = 16'h0001;

  // Characters
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] Ch2     = 8'h32;
  localparam logic [7:0] Ch3     = 8'h33;
  localparam logic [7:0] Ch5     = 8'h35;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [3:0] DigitHi = 4'h3;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_NEWLINE
  } ppmenc_sep_e;

  typedef enum logic [3:0] {
    PH_START,
    PH_P,
    PH_3,
    PH_NL_A,
    PH_WDIG,
    PH_SP,
    PH_HDIG,
    PH_NL_B,
    PH_2,
    PH_5A,
    PH_5B,
    PH_NL_C,
    PH_SEP,
    PH_VAL,
    PH_ROW_NL
  } ppmenc_phase_e;

  typedef struct packed {
    ppmenc_sep_e        sep;
    logic [1:0]         len;
    logic [ValBcdW-1:0] bcd;
  } ppmenc_val_t;

  typedef struct packed {
    logic              header;
    logic              row_end;
    logic              frame_end;
    ppmenc_val_t [2:0] vals;
  } ppmenc_entry_t;

  // 0..255 to three BCD digits
  function automatic logic [ValBcdW-1:0] to_bcd3(logic [7:0] v);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    begin
      if (v >= 8'd200) begin
        hund = 2'd2;
        rem  = 7'(v - 8'd200);
      end else if (v >= 8'd100) begin
        hund = 2'd1;
        rem  = 7'(v - 8'd100);
      end else begin
        hund = 2'd0;
        rem  = v[6:0];
      end
      // rem * 205 / 2048 is rem / 10 for rem below 100
      prod = 15'(rem) * 15'd205;
      tens = prod[14:11];
      ones = 7'(rem - 7'(tens) * 7'd10);
      return {2'b00, hund, tens, ones[3:0]};
    end
  endfunction

  function automatic logic [1:0] bcd3_len(logic [ValBcdW-1:0] bcd);
    if (bcd[11:8] != 4'd0) begin
      return 2'd3;
    end else if (bcd[7:4] != 4'd0) begin
      return 2'd2;
    end
    return 2'd1;
  endfunction

  function automatic logic [2:0] bcd4_len(logic [BcdW-1:0] bcd);
    if (bcd[15:12] != 4'd0) begin
      return 3'd4;
    end else if (bcd[11:8] != 4'd0) begin
      return 3'd3;
    end else if (bcd[7:4] != 4'd0) begin
      return 3'd2;
    end
    return 3'd1;
  endfunction

  // Pick a digit counted from the most significant one
  function automatic logic [3:0] bcd_pick(logic [BcdW-1:0] bcd, logic [1:0] pos);
    logic [3:0] d;
    begin
      unique case (pos)
        2'd0:    d = bcd[15:12];
        2'd1:    d = bcd[11:8];
        2'd2:    d = bcd[7:4];
        default: d = bcd[3:0];
      endcase
      return d;
    end
  endfunction

endpackage

/* rtl/core/ppmenc_if.sv */
interface ppmenc_pix_if import ppmenc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LevelW-1:0] red_level;
  logic signed [LevelW-1:0] green_level;
  logic signed [LevelW-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

interface ppmenc_txt_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, text_byte, run_last, frame_end, input ready);
  modport sink   (input valid, text_byte, run_last, frame_end, output ready);
endinterface

interface ppmenc_cfg_if import ppmenc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ppmenc_bcd_conv.sv */
module ppmenc_bcd_conv import ppmenc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DimW-1:0] value_i,
  output logic            busy_o,
  output logic [BcdW-1:0] bcd_o
);

  localparam int CntW = $clog2(DimW + 1);

  logic [DimW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [BcdW-1:0] adj;

  // Add three to every digit of five or more, then shift one bit in
  always_comb begin
    for (int i = 0; i < BcdW / 4; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[DimW-1]};
      bin_d = {bin_q[DimW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DimW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q  <= BcdOne;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      bcd_q  <= bcd_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

/* rtl/core/ppmenc_front.sv */
module ppmenc_front import ppmenc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppmenc_pix_if.sink        pix_i,
  input  logic              hold_i,
  input  logic [DimW-1:0]   eff_h_i,
  input  logic [ColW-1:0]   w3_i,
  input  logic [LimitW-1:0] limit_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output ppmenc_entry_t     entry_o
);

  logic                      s1_v_q, s2_v_q, s3_v_q;
  logic                      s1_en, s2_en, s3_en, accept;
  logic signed [LevelW-1:0]  lvl_in [3];
  logic [ScaledW-1:0]        scaled [3];
  logic [ScaledW-1:0]        s1_scaled_q [3];
  logic [7:0]                level [3];
  logic [7:0]                s2_lvl_q [3];
  logic [ValBcdW-1:0]        s3_bcd_q [3];
  logic [1:0]                s3_len_q [3];

  logic [ColW-1:0]   col_q, col_d;
  logic [DimW-1:0]   row_q, row_d;
  logic [LimitW-1:0] lc_q, lc_d;

  assign push_o = s3_v_q && push_ready_i;
  assign s3_en  = !s3_v_q || push_o;
  assign s2_en  = !s2_v_q || s3_en;
  assign s1_en  = !s1_v_q || s2_en;
  assign pix_i.ready = s1_en && !hold_i;
  assign accept = pix_i.valid && pix_i.ready;

  always_comb begin
    lvl_in[0] = pix_i.red_level;
    lvl_in[1] = pix_i.green_level;
    lvl_in[2] = pix_i.blue_level;
  end

  // Level times 255 as level * 256 - level
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      scaled[k] = {lvl_in[k], 8'h00} - {{(ScaledW - LevelW){lvl_in[k][LevelW-1]}}, lvl_in[k]};
    end
  end

  // Ceiling of scaled / 65536, clamped to 0..255
  always_comb begin
    logic [ScaledW-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = s1_scaled_q[k] + ScaledW'(16'hFFFF);
      if (s1_scaled_q[k][ScaledW-1] || (s1_scaled_q[k] == '0)) begin
        level[k] = 8'd0;
      end else if (|sum[ScaledW-1:24]) begin
        level[k] = 8'hFF;
      end else begin
        level[k] = sum[23:16];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= accept;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (s1_en) begin
        s1_scaled_q[k] <= scaled[k];
      end
      if (s2_en) begin
        s2_lvl_q[k] <= level[k];
      end
      if (s3_en) begin
        s3_bcd_q[k] <= to_bcd3(s2_lvl_q[k]);
        s3_len_q[k] <= bcd3_len(to_bcd3(s2_lvl_q[k]));
      end
    end
  end

  // Classify: header, separators, row and frame end, and advance the text position
  always_comb begin
    logic [LimitW-1:0] lc;
    logic [LimitW:0]   sum9;
    logic [ColW-1:0]   col_new;
    logic [DimW-1:0]   row_inc;
    entry_o        = '0;
    entry_o.header = (col_q == '0) && (row_q == '0);
    lc             = entry_o.header ? '0 : lc_q;
    for (int k = 0; k < 3; k++) begin
      entry_o.vals[k].bcd = s3_bcd_q[k];
      entry_o.vals[k].len = s3_len_q[k];
      sum9 = {1'b0, lc} + (LimitW + 1)'(s3_len_q[k]);
      if ((k == 0) && (col_q == '0)) begin
        entry_o.vals[k].sep = SEP_NONE;
      end else if (sum9 < {1'b0, limit_i}) begin
        entry_o.vals[k].sep = SEP_SPACE;
        lc = lc + LimitW'(1);
      end else begin
        entry_o.vals[k].sep = SEP_NEWLINE;
        lc = '0;
      end
      lc = lc + LimitW'(s3_len_q[k]);
    end
    col_new           = col_q + ColW'(3);
    row_inc           = row_q + DimW'(1);
    entry_o.row_end   = (col_new >= w3_i);
    entry_o.frame_end = entry_o.row_end && (row_inc >= eff_h_i);
    col_d = col_q;
    row_d = row_q;
    lc_d  = lc_q;
    if (push_o) begin
      if (entry_o.row_end) begin
        col_d = '0;
        lc_d  = '0;
        row_d = entry_o.frame_end ? '0 : row_inc;
      end else begin
        col_d = col_new;
        lc_d  = lc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      lc_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      lc_q  <= lc_d;
    end
  end

endmodule

/* rtl/core/ppmenc_queue.sv */
module ppmenc_queue import ppmenc_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  ppmenc_entry_t entry_i,
  output logic          head_valid_o,
  input  logic          pop_i,
  output ppmenc_entry_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ppmenc_entry_t   mem [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/core/ppmenc_back.sv */
module ppmenc_back import ppmenc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ppmenc_entry_t   head_i,
  output logic            pop_o,
  input  logic [BcdW-1:0] w_bcd_i,
  input  logic [BcdW-1:0] h_bcd_i,
  ppmenc_txt_if.source    txt_o
);

  ppmenc_phase_e ph_q, ph_d, eph;
  logic [1:0]    cnt_q, cnt_d, val_q, val_d;
  logic          emit;
  logic [7:0]    byte_d, byte_q;
  logic          last_d, last_q, frame_d, frame_q, out_v_q;
  logic [2:0]    nd_w, nd_h;
  ppmenc_val_t   cur;
  logic          val_done;
  logic [1:0]    vpos, wpos, hpos;

  assign emit = head_valid_i && (!out_v_q || txt_o.ready);
  assign nd_w = bcd4_len(w_bcd_i);
  assign nd_h = bcd4_len(h_bcd_i);
  assign cur  = head_i.vals[val_q];
  assign vpos = 2'(3'd4 - {1'b0, cur.len} + {1'b0, cnt_q});
  assign wpos = 2'(3'd4 - nd_w + {1'b0, cnt_q});
  assign hpos = 2'(3'd4 - nd_h + {1'b0, cnt_q});
  assign val_done = (cnt_q == cur.len - 2'd1);

  // Resolve the first phase of a fresh entry from its head
  always_comb begin
    if (ph_q == PH_START) begin
      if (head_i.header) begin
        eph = PH_P;
      end else if (head_i.vals[0].sep != SEP_NONE) begin
        eph = PH_SEP;
      end else begin
        eph = PH_VAL;
      end
    end else begin
      eph = ph_q;
    end
  end

  // Next state
  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    val_d = val_q;
    if (emit) begin
      unique case (eph)
        PH_P:    ph_d = PH_3;
        PH_3:    ph_d = PH_NL_A;
        PH_NL_A: ph_d = PH_WDIG;
        PH_WDIG: begin
          if (cnt_q == 2'(nd_w - 3'd1)) begin
            cnt_d = '0;
            ph_d  = PH_SP;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_SP:   ph_d = PH_HDIG;
        PH_HDIG: begin
          if (cnt_q == 2'(nd_h - 3'd1)) begin
            cnt_d = '0;
            ph_d  = PH_NL_B;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_NL_B: ph_d = PH_2;
        PH_2:    ph_d = PH_5A;
        PH_5A:   ph_d = PH_5B;
        PH_5B:   ph_d = PH_NL_C;
        PH_NL_C: ph_d = (head_i.vals[0].sep != SEP_NONE) ? PH_SEP : PH_VAL;
        PH_SEP:  ph_d = PH_VAL;
        PH_VAL: begin
          if (val_done) begin
            cnt_d = '0;
            if (val_q == 2'd2) begin
              val_d = '0;
              ph_d  = head_i.row_end ? PH_ROW_NL : PH_START;
            end else begin
              val_d = val_q + 2'd1;
              ph_d  = (head_i.vals[val_q + 2'd1].sep != SEP_NONE) ? PH_SEP : PH_VAL;
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_ROW_NL: ph_d = PH_START;
        default:   ph_d = PH_START;
      endcase
    end
  end

  // Outputs
  always_comb begin
    byte_d  = ChNl;
    last_d  = 1'b0;
    frame_d = 1'b0;
    unique case (eph)
      PH_P:    byte_d = ChP;
      PH_3:    byte_d = Ch3;
      PH_WDIG: byte_d = {DigitHi, bcd_pick(w_bcd_i, wpos)};
      PH_SP:   byte_d = ChSpace;
      PH_HDIG: byte_d = {DigitHi, bcd_pick(h_bcd_i, hpos)};
      PH_2:    byte_d = Ch2;
      PH_5A:   byte_d = Ch5;
      PH_5B:   byte_d = Ch5;
      PH_SEP:  byte_d = (cur.sep == SEP_SPACE) ? ChSpace : ChNl;
      PH_VAL: begin
        byte_d = {DigitHi, bcd_pick({4'h0, cur.bcd}, vpos)};
        last_d = val_done && (val_q == 2'd2) && !head_i.row_end;
      end
      PH_ROW_NL: begin
        last_d  = 1'b1;
        frame_d = head_i.frame_end;
      end
      default: byte_d = ChNl;
    endcase
    pop_o = emit && last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_START;
      cnt_q   <= '0;
      val_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      val_q <= val_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (txt_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= byte_d;
      last_q  <= last_d;
      frame_q <= frame_d;
    end
  end

  assign txt_o.valid     = out_v_q;
  assign txt_o.text_byte = byte_q;
  assign txt_o.run_last  = last_q;
  assign txt_o.frame_end = frame_q;

endmodule

/* rtl/core/ppm_ascii_pixel_encoder_unit.sv */
// Plain-text PPM encoder: one pixel in, its decimal text out, one byte per cycle
// while the receiver is ready. A pixel's first byte passes the scale, round and digit
// stages, the queue and the output register. The byte sequencer bounds the rate: a
// pixel's text is 5 to 13 bytes, plus 11 to 17 header bytes ahead of each frame.
// Reset: text position cleared, width 1, height 1, line limit 70. A width or height
// write holds the pixel input while the new size is turned to decimal.
module ppm_ascii_pixel_encoder_unit import ppmenc_pkg::*; #(
  parameter int DIM_BITS    = DimBitsDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ppmenc_cfg_if.sink   cfg_i,
  ppmenc_pix_if.sink   pix_i,
  ppmenc_txt_if.source txt_o
);

  // Size fields keep only DIM_BITS bits, and never more than the register holds
  localparam logic [DimW-1:0] DimMask = DimW'((33'd1 << DIM_BITS) - 33'd1);

  logic [DimW-1:0]   w_q, h_q;
  logic [LimitW-1:0] limit_q;
  logic [DimW-1:0]   w_m, h_m, eff_w, eff_h;
  logic [ColW-1:0]   w3;
  logic              cfg_fire, conv_start_q;
  logic              w_busy, h_busy, hold;
  logic [BcdW-1:0]   w_bcd, h_bcd;

  logic          push, push_ready, head_valid, pop;
  ppmenc_entry_t push_entry, head_entry;

  // Configuration: always ready; it is to be written only between frames, a rule left to the user
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q          <= WidthReset;
      h_q          <= HeightReset;
      limit_q      <= LimitReset;
      conv_start_q <= 1'b0;
    end else begin
      conv_start_q <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_i.index)
          RegWidth: begin
            w_q          <= cfg_i.data;
            conv_start_q <= 1'b1;
          end
          RegHeight: begin
            h_q          <= cfg_i.data;
            conv_start_q <= 1'b1;
          end
          RegLimit: limit_q <= cfg_i.data[LimitW-1:0];
          default: ;
        endcase
      end
    end
  end

  // A zero size acts as one
  assign w_m   = w_q & DimMask;
  assign h_m   = h_q & DimMask;
  assign eff_w = (w_m == '0) ? DimW'(1) : w_m;
  assign eff_h = (h_m == '0) ? DimW'(1) : h_m;
  // Values per row: three per pixel
  assign w3    = {1'b0, eff_w, 1'b0} + {2'b00, eff_w};

  // Decimal forms of the sizes for the header, refreshed after each size write
  ppmenc_bcd_conv u_w_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start_q),
    .value_i (eff_w),
    .busy_o  (w_busy),
    .bcd_o   (w_bcd)
  );

  ppmenc_bcd_conv u_h_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start_q),
    .value_i (eff_h),
    .busy_o  (h_busy),
    .bcd_o   (h_bcd)
  );

  // Hold the pixel input until the header digits are ready
  assign hold = conv_start_q || w_busy || h_busy;

  // Front: scale, round, split into digits and plan separators
  ppmenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .hold_i       (hold),
    .eff_h_i      (eff_h),
    .w3_i         (w3),
    .limit_i      (limit_q),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  // Short queue of planned pixels lets the two halves stall on their own
  ppmenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .entry_i      (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head_entry)
  );

  // Back: sequence the bytes of each planned pixel into the output register
  ppmenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .w_bcd_i      (w_bcd),
    .h_bcd_i      (h_bcd),
    .txt_o        (txt_o)
  );

`ifndef SYNTHESIS
  // No pixel transfer while the header digits are being rebuilt
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |-> !(pix_i.valid && pix_i.ready))
    else $error("pixel transferred during size conversion");

  // The image ends only on the last byte of a pixel
  a_frame_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (txt_o.valid && txt_o.frame_end) |-> (txt_o.run_last && txt_o.text_byte == ChNl))
    else $error("frame end away from a row-ending newline");

  // A pixel's text closes with a digit or a newline
  a_last_byte_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (txt_o.valid && txt_o.run_last) |->
      (txt_o.text_byte == ChNl || txt_o.text_byte[7:4] == DigitHi))
    else $error("pixel text closes with an unexpected byte");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ready)
    else $error("queue overflow");
`endif

endmodule

/* tb/ppm_ascii_pixel_encoder_unit_tb.sv */
module ppm_ascii_pixel_encoder_unit_tb;
  import ppmenc_pkg::*;

  // Generous ceiling: the slowest legal run (every pixel at its longest text,
  // every byte stalled by the receiver, every pixel delayed by the sender and
  // the long hold-off) stays far below this.
  localparam int CycleLimit   = 400000;
  // Extra time for the pipe to settle once the owed text is out.
  localparam int SettleCycles = 8;
  localparam int ReportCap    = 40;
  localparam int HoldCycles   = 400;

  // Index 3 decodes to no register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef logic signed [LevelW-1:0] level_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       run_last;
    logic       frame_end;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ppmenc_cfg_if cfg_if ();
  ppmenc_pix_if pix_if ();
  ppmenc_txt_if txt_if ();

  ppm_ascii_pixel_encoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .txt_o  (txt_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder shadow: register copies and text position, updated on every
  // accepted register write and pixel transfer.
  // ---------------------------------------------------------------------------
  logic [DimW-1:0]   width_reg  = WidthReset;
  logic [DimW-1:0]   height_reg = HeightReset;
  logic [LimitW-1:0] limit_reg  = LimitReset;
  logic [ColW-1:0]   value_col  = '0;
  logic [DimW-1:0]   row_pos    = '0;
  logic [7:0]        line_len   = '0;

  // Bytes of the pixel being worked out, then the text still owed by the block.
  logic [7:0] run_bytes[$];
  text_beat_t text_expected[$];

  int  mismatch_count  = 0;
  int  sender_idle_pct = 0;
  int  stall_pct       = 0;
  logic hold_off       = 1'b0;
  text_beat_t oldest_beat;

  function automatic int level_to_code(level_t lvl);
    longint scaled;
    longint rounded;
    // Scale by 255, take the exact ceiling of the Q23.16 result, clamp.
    scaled = longint'(lvl) * 64'sd255;
    if (scaled <= 0) return 0;
    rounded = (scaled + 65535) / 65536;
    return (rounded > 255) ? 255 : int'(rounded);
  endfunction

  function automatic int digit_count(int v);
    int n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  function automatic void push_char(logic [7:0] ch);
    run_bytes = {run_bytes, ch};
  endfunction

  function automatic void push_decimal(int v);
    int scale;
    scale = 1;
    while (v / scale >= 10) scale = scale * 10;
    while (scale > 0) begin
      push_char({DigitHi, 4'((v / scale) % 10)});
      scale = scale / 10;
    end
  endfunction

  function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      RegWidth: begin
        width_reg = val[DimW-1:0];
      end
      RegHeight: begin
        height_reg = val[DimW-1:0];
      end
      RegLimit: begin
        limit_reg = val[LimitW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Work out the text one pixel causes and queue it with its flags.
  function automatic void predict_pixel_text(level_t red, level_t green, level_t blue);
    level_t     levels [3];
    int         span_w;
    int         span_h;
    int         code;
    int         len;
    bit         frame_done;
    text_beat_t beat;
    levels[0] = red;
    levels[1] = green;
    levels[2] = blue;
    // A zero size register behaves as one.
    span_w = (width_reg == '0) ? 1 : int'(width_reg);
    span_h = (height_reg == '0) ? 1 : int'(height_reg);
    frame_done = 1'b0;
    run_bytes.delete();

    // Header before the first pixel of a frame.
    if (value_col == '0 && row_pos == '0) begin
      push_char(ChP);
      push_char(Ch3);
      push_char(ChNl);
      push_decimal(span_w);
      push_char(ChSpace);
      push_decimal(span_h);
      push_char(ChNl);
      push_char(Ch2);
      push_char(Ch5);
      push_char(Ch5);
      push_char(ChNl);
      line_len = '0;
    end

    for (int c = 0; c < 3; c++) begin
      code = level_to_code(levels[c]);
      len  = digit_count(code);
      // Separator ahead of every value but the first of a row: a space while
      // the line stays under the limit, otherwise break the line.
      if (value_col != '0) begin
        if (int'(line_len) + len < int'(limit_reg)) begin
          push_char(ChSpace);
          line_len = line_len + 8'd1;
        end else begin
          push_char(ChNl);
          line_len = '0;
        end
      end
      push_decimal(code);
      line_len  = line_len + 8'(len);
      value_col = value_col + 1'b1;
    end

    // Row end once the column reaches or passes three values per pixel;
    // frame end once the row reaches or passes the height.
    if (int'(value_col) >= 3 * span_w) begin
      push_char(ChNl);
      line_len  = '0;
      value_col = '0;
      row_pos   = row_pos + 1'b1;
      if (int'(row_pos) >= span_h) begin
        row_pos    = '0;
        frame_done = 1'b1;
      end
    end

    foreach (run_bytes[i]) begin
      beat.text_byte = run_bytes[i];
      beat.run_last  = (i == run_bytes.size() - 1);
      beat.frame_end = (i == run_bytes.size() - 1) && frame_done;
      text_expected = {text_expected, beat};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text receiver: low in reset, random stalls, or a solid hold-off when asked.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_off || !rst_ni) begin
      txt_if.ready <= 1'b0;
    end else begin
      txt_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < ReportCap) begin
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Compare every byte transfer against the oldest owed byte.
  always @(posedge clk_i) begin
    if (rst_ni && txt_if.valid && txt_if.ready) begin
      if (text_expected.size() == 0) begin
        report_mismatch("byte with nothing owed", txt_if.text_byte, 0);
      end else begin
        oldest_beat = text_expected.pop_front();
        if (txt_if.text_byte !== oldest_beat.text_byte) begin
          report_mismatch("text_byte", txt_if.text_byte, oldest_beat.text_byte);
        end
        if (txt_if.run_last !== oldest_beat.run_last) begin
          report_mismatch("run_last", txt_if.run_last, oldest_beat.run_last);
        end
        if (txt_if.frame_end !== oldest_beat.frame_end) begin
          report_mismatch("frame_end", txt_if.frame_end, oldest_beat.frame_end);
        end
      end
    end
  end

  // Cycle counter: end the run if it never completes.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one pixel; valid stays high into the next call so back-to-back
  // transfers need no gap. Idle cycles lower it first.
  task automatic send_pixel(level_t red, level_t green, level_t blue);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.red_level   <= red;
    pix_if.green_level <= green;
    pix_if.blue_level  <= blue;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_pixel_text(red, green, blue);
  endtask

  // Drop the pixel valid, then wait until all owed text has come out.
  task automatic wait_text_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (text_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Call only with the block idle.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_register(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic level_t random_level();
    level_t lvl;
    case ($urandom_range(0, 7))
      0: begin
        // Edges of the fixed-point range and of the full-scale point.
        case ($urandom_range(0, 7))
          0:       lvl = 32'sh0;
          1:       lvl = 32'sh1;
          2:       lvl = -32'sh1;
          3:       lvl = 32'sh7FFFFFFF;
          4:       lvl = 32'sh80000000;
          5:       lvl = 32'sh10000;
          6:       lvl = 32'sh10001;
          default: lvl = 32'shFFFF;
        endcase
      end
      1, 2, 3: lvl = level_t'($urandom_range(0, 32'h10000));
      4:       lvl = -level_t'($urandom_range(0, 32'h10000));
      default: lvl = level_t'($urandom());
    endcase
    return lvl;
  endfunction

  // Small sizes mostly, now and then a wide row so the line limit bites.
  task automatic write_random_setup();
    logic [CfgDataW-1:0] span;
    logic [CfgDataW-1:0] limit;
    if ($urandom_range(0, 5) == 0) begin
      span = 12'($urandom_range(9, 4095));
    end else begin
      span = 12'($urandom_range(1, 6));
    end
    write_register(RegWidth, span);
    write_register(RegHeight, 12'($urandom_range(0, 4)));
    case ($urandom_range(0, 5))
      0:       limit = 12'($urandom_range(0, 7));
      1:       limit = 12'd255;
      default: limit = 12'($urandom_range(8, 40));
    endcase
    write_register(RegLimit, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sizes: every pixel is a whole one-pixel frame with its own header.
  // Covers negative, zero, tiny, half, full and saturating levels.
  task automatic test_level_extremes();
    send_pixel(32'sh0, -32'sh1, 32'sh10000);
    send_pixel(32'sh7FFFFFFF, 32'sh80000000, 32'sh100);
    send_pixel(32'sh8000, 32'sh1000, 32'sh10001);
    wait_text_drained();
  endtask

  // Zero width and height act as one, and the header prints the one.
  task automatic test_zero_size();
    write_register(RegWidth, 12'd0);
    write_register(RegHeight, 12'd0);
    send_pixel(32'sh2000, 32'sh1, 32'shFFFF);
    wait_text_drained();
  endtask

  // Two by two frame: row ends after two pixels, frame end on the last.
  task automatic test_rows_and_frame();
    write_register(RegWidth, 12'd2);
    write_register(RegHeight, 12'd2);
    write_register(RegLimit, 12'd70);
    send_pixel(32'sh1, 32'sh1000, 32'sh8000);
    send_pixel(32'sh10000, -32'sh10000, 32'sh900);
    send_pixel(32'sh5000, 32'sh0, 32'sh7FFFFFFF);
    send_pixel(32'sh80000000, 32'sh3000, 32'shA000);
    wait_text_drained();
  endtask

  // Limit of zero: nothing fits, so break before every value but the first.
  // Limit of eight: one three-digit pair fits on a line, not three.
  task automatic test_small_line_limit();
    write_register(RegLimit, 12'd0);
    write_register(RegWidth, 12'd2);
    write_register(RegHeight, 12'd1);
    send_pixel(32'sh10000, 32'sh10000, 32'sh10000);
    send_pixel(32'sh1, 32'sh8000, 32'sh10000);
    wait_text_drained();
    write_register(RegLimit, 12'd8);
    send_pixel(32'sh10000, 32'sh10000, 32'sh10000);
    send_pixel(32'sh10000, 32'sh1, 32'sh10000);
    wait_text_drained();
  endtask

  // Largest sizes give four-digit header fields; shrinking the width and
  // height mid-frame then ends the row and the frame early.
  task automatic test_resize_mid_frame();
    write_register(RegLimit, 12'd255);
    write_register(RegWidth, 12'd4095);
    write_register(RegHeight, 12'd4095);
    write_register(RegSpare, 12'hFFF);
    send_pixel(32'sh10000, 32'sh8000, 32'sh1);
    send_pixel(32'sh4000, 32'sh6000, 32'shC000);
    wait_text_drained();
    write_register(RegWidth, 12'd1);
    send_pixel(32'sh2800, 32'sh0, 32'sh10000);
    wait_text_drained();
    write_register(RegHeight, 12'd1);
    send_pixel(32'sh1, 32'sh7FFF, 32'sh10000);
    wait_text_drained();
  endtask

  // Hold the receiver off while pixels keep coming, so the block fills and
  // stalls its input; then release and check nothing was lost.
  task automatic test_input_backpressure();
    write_register(RegWidth, 12'd3);
    write_register(RegHeight, 12'd2);
    write_register(RegLimit, 12'd70);
    sender_idle_pct = 0;
    stall_pct       = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    repeat (10) send_pixel(random_level(), random_level(), random_level());
    wait_text_drained();
  endtask

  // Random pixels under one idling pattern, in two halves with a fresh
  // random setup each; frames need not be complete across a setup change.
  task automatic test_random_traffic(int idle_pct, int stall, int pixels);
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
    for (int half = 0; half < 2; half++) begin
      write_random_setup();
      repeat (pixels / 2) send_pixel(random_level(), random_level(), random_level());
      wait_text_drained();
    end
    sender_idle_pct = 0;
    stall_pct       = 0;
  endtask

  initial begin
    // Initialise every input before the first edge, then hold and release reset.
    rst_ni             <= 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.red_level   <= '0;
    pix_if.green_level <= '0;
    pix_if.blue_level  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= RegWidth;
    cfg_if.data        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_level_extremes();
    test_zero_size();
    test_rows_and_frame();
    test_small_line_limit();
    test_resize_mid_frame();
    test_input_backpressure();
    test_random_traffic(0, 0, 34);
    test_random_traffic(81, 0, 34);
    test_random_traffic(0, 81, 34);
    test_random_traffic(28, 28, 34);

    wait_text_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
